// ===== hw/rtl/servo_position_sweep_ramp_top_defines.svh =====
// ----------------------------------------------------------------------------
// Servo ramp assertion macros
// Shared assertion helpers for the servo position sweep ramp block.
// ----------------------------------------------------------------------------
`ifndef SERVO_POSITION_SWEEP_RAMP_TOP_DEFINES_SVH
`define SERVO_POSITION_SWEEP_RAMP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define SPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPR_ASSERT(lbl, prop, msg)
`define SPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo ramp package
// Item types, register map, micro-op codes and helper functions.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Input and result items.
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] position_value;
    logic [1:0]  direction;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] position;
    logic        pwm_enable;
    logic [15:0] compare_value;
    logic [1:0]  sweep_state;
  } out_item_t;

  // Configuration register file.
  typedef struct packed {
    logic [15:0] open_limit;
    logic [15:0] closed_limit;
    logic [15:0] pwm_scale;
    logic [15:0] pwm_top;
    logic [15:0] sweep_rate;
    logic [15:0] tick_min_ms;
  } cfg_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MIN_MS  = 3'd5;

  localparam logic [15:0] RST_OPEN_LIMIT   = 16'd1000;
  localparam logic [15:0] RST_CLOSED_LIMIT = 16'd2000;
  localparam logic [15:0] RST_PWM_SCALE    = 16'd20000;
  localparam logic [15:0] RST_PWM_TOP      = 16'd40000;
  localparam logic [15:0] RST_SWEEP_RATE   = 16'd500;
  localparam logic [15:0] RST_TICK_MIN_MS  = 16'd20;
  localparam logic [15:0] RST_POSITION =
    16'((32'(RST_OPEN_LIMIT) + 32'(RST_CLOSED_LIMIT)) / 2);

  // Command and direction codes.
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_DIR  = 2'd1;
  localparam logic [1:0] OP_TGT  = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] DIR_STOP   = 2'd0;
  localparam logic [1:0] DIR_OPEN   = 2'd1;
  localparam logic [1:0] DIR_CLOSE  = 2'd2;
  localparam logic [1:0] DIR_UNUSED = 2'd3;

  // Rate arithmetic: milliseconds per second and its scaled reciprocal.
  localparam logic [9:0]  MS_PER_S     = 10'd1000;
  localparam int unsigned RECIP_SHIFT  = 36;
  localparam logic [26:0] RECIP_1000   = 27'((64'd1 << RECIP_SHIFT) / 64'd1000);
  localparam int unsigned STEP_W       = 17;
  localparam int unsigned ADV_W        = 49;
  // Advances from here on move at least a full 16-bit span.
  localparam logic [ADV_W-1:0] ADV_BIG_LIM = ADV_W'(64'd65536 * 64'd1000);

  // Micro-ops executed by the datapath.
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_SET_CMD,
    ACT_DIR_CMD,
    ACT_TGT_CMD,
    ACT_ELAPSED,
    ACT_ADD_REM,
    ACT_SAT_IF_BIG,
    ACT_QUOT,
    ACT_REM_FIX,
    ACT_EVAL,
    ACT_DRIVE_NPOS,
    ACT_FINISH,
    ACT_SAT_S,
    ACT_DIV_START,
    ACT_CMP_FROM_DIV,
    ACT_CMP_ZERO,
    ACT_LOAD_OUT
  } act_e;

  // Operand pairs for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RATE_EL,
    MUL_RECIP,
    MUL_QK,
    MUL_POS_TOP
  } mul_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_NO_IN,
    C_OUT_BUSY,
    C_DIR_ZERO,
    C_EL_SHORT,
    C_ADV_BIG,
    C_STEP_ZERO,
    C_FIN,
    C_CMP_OFF,
    C_DIV_BUSY
  } cond_e;

  localparam int unsigned UPC_W = 5;

  typedef struct packed {
    act_e             act;
    mul_e             mul;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       no_in;
    logic       out_busy;
    logic       dir_zero;
    logic       el_short;
    logic       adv_big;
    logic       step_zero;
    logic       fin;
    logic       cmp_off;
    logic       div_busy;
  } stat_t;

  // Nonzero positions are pulled inside the limits, open limit tested first.
  function automatic logic [15:0] clamp_pos(input logic [15:0] s,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] r;
    begin
      if (s == 16'd0) r = 16'd0;
      else if (s < lo) r = lo;
      else if (s > hi) r = hi;
      else r = s;
      return r;
    end
  endfunction

  // Target limiting: like clamping, but zero is pulled up as well.
  function automatic logic [15:0] limit_target(input logic [15:0] s,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
    logic [15:0] r;
    begin
      if (s < lo) r = lo;
      else if (s > hi) r = hi;
      else r = s;
      return r;
    end
  endfunction

endpackage

// ===== hw/rtl/spr_div.sv =====
// ----------------------------------------------------------------------------
// Servo ramp compare divider
// Restoring divider, one quotient bit per cycle, for the PWM compare scaling.
// ----------------------------------------------------------------------------
module spr_div
  import spr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [15:0] quot_o
);

  // The dividend is known to be below divisor times 2^16.
  localparam int unsigned QW    = 16;
  localparam int unsigned CNT_W = $clog2(QW);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      dsh_q, dsh_d;
  logic [QW-1:0]    quot_q, quot_d;

  // One compare and subtract per cycle, divisor shifting down.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QW - 1);
      rem_d  = dividend_i;
      dsh_d  = {1'b0, divisor_i, 15'b0};
      quot_d = '0;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_d  = rem_q - dsh_q;
        quot_d = {quot_q[QW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[QW-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/spr_seq.sv =====
// ----------------------------------------------------------------------------
// Servo ramp microsequencer
// Step counter and control store holding the command program.
// ----------------------------------------------------------------------------
`include "servo_position_sweep_ramp_top_defines.svh"

module spr_seq
  import spr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  // Program addresses.
  localparam logic [UPC_W-1:0] U_FETCH     = 5'd0;
  localparam logic [UPC_W-1:0] U_DISPATCH  = 5'd1;
  localparam logic [UPC_W-1:0] U_SET       = 5'd2;
  localparam logic [UPC_W-1:0] U_DIR       = 5'd3;
  localparam logic [UPC_W-1:0] U_TGT       = 5'd4;
  localparam logic [UPC_W-1:0] U_TICK      = 5'd5;
  localparam logic [UPC_W-1:0] U_TK_MUL    = 5'd6;
  localparam logic [UPC_W-1:0] U_TK_ADD    = 5'd7;
  localparam logic [UPC_W-1:0] U_TK_RECIP  = 5'd8;
  localparam logic [UPC_W-1:0] U_TK_QUOT   = 5'd9;
  localparam logic [UPC_W-1:0] U_TK_QK     = 5'd10;
  localparam logic [UPC_W-1:0] U_TK_REM    = 5'd11;
  localparam logic [UPC_W-1:0] U_TK_CHK    = 5'd12;
  localparam logic [UPC_W-1:0] U_TK_EVAL   = 5'd13;
  localparam logic [UPC_W-1:0] U_TK_FIN    = 5'd14;
  localparam logic [UPC_W-1:0] U_TK_DRIVE  = 5'd15;
  localparam logic [UPC_W-1:0] U_TK_FINISH = 5'd16;
  localparam logic [UPC_W-1:0] U_CMP       = 5'd17;
  localparam logic [UPC_W-1:0] U_CMP_MUL   = 5'd18;
  localparam logic [UPC_W-1:0] U_CMP_DIV   = 5'd19;
  localparam logic [UPC_W-1:0] U_CMP_WAIT  = 5'd20;
  localparam logic [UPC_W-1:0] U_OUT       = 5'd21;
  localparam logic [UPC_W-1:0] U_RET       = 5'd22;
  localparam logic [UPC_W-1:0] U_CMP_ZERO  = 5'd23;
  localparam logic [UPC_W-1:0] U_LAST      = U_CMP_ZERO;

  function automatic ctrl_t mk(input act_e a, input mul_e m, input cond_e c,
                               input logic [UPC_W-1:0] t);
    ctrl_t w;
    begin
      w.act    = a;
      w.mul    = m;
      w.cond   = c;
      w.target = t;
      return w;
    end
  endfunction

  // Control store: one word per step.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] a);
    ctrl_t w;
    begin
      case (a)
        U_FETCH:     w = mk(ACT_LATCH,        MUL_NONE,    C_NO_IN,     U_FETCH);
        U_DISPATCH:  w = mk(ACT_NONE,         MUL_NONE,    C_DISPATCH,  U_SET);
        U_SET:       w = mk(ACT_SET_CMD,      MUL_NONE,    C_ALWAYS,    U_CMP);
        U_DIR:       w = mk(ACT_DIR_CMD,      MUL_NONE,    C_ALWAYS,    U_CMP);
        U_TGT:       w = mk(ACT_TGT_CMD,      MUL_NONE,    C_ALWAYS,    U_CMP);
        U_TICK:      w = mk(ACT_ELAPSED,      MUL_NONE,    C_DIR_ZERO,  U_CMP);
        U_TK_MUL:    w = mk(ACT_NONE,         MUL_RATE_EL, C_EL_SHORT,  U_CMP);
        U_TK_ADD:    w = mk(ACT_ADD_REM,      MUL_NONE,    C_NEXT,      U_FETCH);
        U_TK_RECIP:  w = mk(ACT_SAT_IF_BIG,   MUL_RECIP,   C_ADV_BIG,   U_TK_EVAL);
        U_TK_QUOT:   w = mk(ACT_QUOT,         MUL_NONE,    C_NEXT,      U_FETCH);
        U_TK_QK:     w = mk(ACT_NONE,         MUL_QK,      C_NEXT,      U_FETCH);
        U_TK_REM:    w = mk(ACT_REM_FIX,      MUL_NONE,    C_NEXT,      U_FETCH);
        U_TK_CHK:    w = mk(ACT_NONE,         MUL_NONE,    C_STEP_ZERO, U_CMP);
        U_TK_EVAL:   w = mk(ACT_EVAL,         MUL_NONE,    C_NEXT,      U_FETCH);
        U_TK_FIN:    w = mk(ACT_NONE,         MUL_NONE,    C_FIN,       U_TK_FINISH);
        U_TK_DRIVE:  w = mk(ACT_DRIVE_NPOS,   MUL_NONE,    C_ALWAYS,    U_CMP);
        U_TK_FINISH: w = mk(ACT_FINISH,       MUL_NONE,    C_ALWAYS,    U_CMP);
        U_CMP:       w = mk(ACT_SAT_S,        MUL_NONE,    C_CMP_OFF,   U_CMP_ZERO);
        U_CMP_MUL:   w = mk(ACT_NONE,         MUL_POS_TOP, C_NEXT,      U_FETCH);
        U_CMP_DIV:   w = mk(ACT_DIV_START,    MUL_NONE,    C_NEXT,      U_FETCH);
        U_CMP_WAIT:  w = mk(ACT_CMP_FROM_DIV, MUL_NONE,    C_DIV_BUSY,  U_CMP_WAIT);
        U_OUT:       w = mk(ACT_LOAD_OUT,     MUL_NONE,    C_OUT_BUSY,  U_OUT);
        U_RET:       w = mk(ACT_NONE,         MUL_NONE,    C_ALWAYS,    U_FETCH);
        U_CMP_ZERO:  w = mk(ACT_CMP_ZERO,     MUL_NONE,    C_ALWAYS,    U_OUT);
        default:     w = mk(ACT_NONE,         MUL_NONE,    C_ALWAYS,    U_FETCH);
      endcase
      return w;
    end
  endfunction

  logic [UPC_W-1:0] pc_q, pc_d;
  logic [UPC_W-1:0] pc_inc;
  logic             take;
  ctrl_t            ctrl;

  assign ctrl   = ucode(pc_q);
  assign pc_inc = pc_q + UPC_W'(1);

  // Condition select and next step.
  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = stat_i.no_in;
      C_OUT_BUSY:  take = stat_i.out_busy;
      C_DIR_ZERO:  take = stat_i.dir_zero;
      C_EL_SHORT:  take = stat_i.el_short;
      C_ADV_BIG:   take = stat_i.adv_big;
      C_STEP_ZERO: take = stat_i.step_zero;
      C_FIN:       take = stat_i.fin;
      C_CMP_OFF:   take = stat_i.cmp_off;
      C_DIV_BUSY:  take = stat_i.div_busy;
      default:     take = 1'b0;
    endcase

    if (ctrl.cond == C_DISPATCH) begin
      case (stat_i.op)
        OP_SET:  pc_d = U_SET;
        OP_DIR:  pc_d = U_DIR;
        OP_TGT:  pc_d = U_TGT;
        OP_TICK: pc_d = U_TICK;
        default: pc_d = U_TICK;
      endcase
    end else if (take) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= U_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

  `SPR_ASSERT(a_upc_range, pc_q <= U_LAST, "step counter left the program")
  `SPR_ASSERT(a_fetch_dispatch, (ctrl.act == ACT_LATCH && !stat_i.no_in) |=> (pc_q == U_DISPATCH), "accepted item not dispatched")
  `SPR_ASSERT(a_div_started, (pc_q == U_CMP_DIV) |=> stat_i.div_busy, "divider did not start")

endmodule

// ===== hw/rtl/spr_dp.sv =====
// ----------------------------------------------------------------------------
// Servo ramp datapath
// Servo state, work registers, shared multiplier and the result register.
// ----------------------------------------------------------------------------
`include "servo_position_sweep_ramp_top_defines.svh"

module spr_dp
  import spr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  ctrl_t     ctrl_i,
  output stat_t     stat_o,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  // Servo state.
  logic [15:0] pos_q, pos_d;
  logic        pwm_q, pwm_d;
  logic [1:0]  dir_q, dir_d;
  logic [15:0] tgt_q, tgt_d;
  logic        tgt_act_q, tgt_act_d;
  logic [9:0]  rem_q, rem_d;
  logic [31:0] last_q, last_d;

  // Work registers.
  in_item_t          cmd_q, cmd_d;
  logic [31:0]       elapsed_q, elapsed_d;
  logic [63:0]       prod_q, prod_d;
  logic [ADV_W-1:0]  adv_q, adv_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [15:0]       npos_q, npos_d;
  logic [15:0]       bound_q, bound_d;
  logic              fin_q, fin_d;
  logic [15:0]       s_q, s_d;
  logic [15:0]       cmp_q, cmp_d;

  // Result register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [31:0] mul_a, mul_b;
  logic [15:0] set_pos, cur_clamped, tgt_lim, tgt_base;
  logic [15:0] eval_bound, eval_npos;
  logic        eval_fin;
  logic [10:0] rfix;
  logic        adv_big, out_busy;
  logic        div_busy;
  logic [15:0] div_quot;

  assign adv_big  = adv_q >= ADV_BIG_LIM;
  assign out_busy = out_valid_q && !out_ready_i;

  assign set_pos     = clamp_pos(cmd_q.position_value, cfg_i.open_limit, cfg_i.closed_limit);
  assign cur_clamped = clamp_pos(pos_q, cfg_i.open_limit, cfg_i.closed_limit);
  assign tgt_lim     = limit_target(cmd_q.position_value, cfg_i.open_limit,
                                    cfg_i.closed_limit);
  assign tgt_base    = pwm_q ? pos_q : cur_clamped;
  // Remainder before correction; the true value stays below twice 1000.
  assign rfix        = adv_q[10:0] - prod_q[10:0];

  // Sweep step evaluation against the active bound.
  always_comb begin
    if (tgt_act_q) eval_bound = tgt_q;
    else if (dir_q == DIR_OPEN) eval_bound = cfg_i.open_limit;
    else eval_bound = cfg_i.closed_limit;

    if (dir_q == DIR_OPEN) begin
      eval_fin  = {2'b0, pos_q} <= ({2'b0, eval_bound} + {1'b0, step_q});
      eval_npos = pos_q - step_q[15:0];
    end else begin
      eval_fin  = ({2'b0, pos_q} + {1'b0, step_q}) >= {2'b0, eval_bound};
      eval_npos = pos_q + step_q[15:0];
    end
  end

  // Multiplier operand select.
  always_comb begin
    case (ctrl_i.mul)
      MUL_RATE_EL: begin
        mul_a = elapsed_q;
        mul_b = {16'b0, cfg_i.sweep_rate};
      end
      MUL_RECIP: begin
        mul_a = {6'b0, adv_q[25:0]};
        mul_b = {5'b0, RECIP_1000};
      end
      MUL_QK: begin
        mul_a = {15'b0, step_q};
        mul_b = {22'b0, MS_PER_S};
      end
      MUL_POS_TOP: begin
        mul_a = {16'b0, s_q};
        mul_b = {16'b0, cfg_i.pwm_top};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = (ctrl_i.mul == MUL_NONE) ? prod_q : (mul_a * mul_b);
  end

  // Micro-op execution.
  always_comb begin
    pos_d       = pos_q;
    pwm_d       = pwm_q;
    dir_d       = dir_q;
    tgt_d       = tgt_q;
    tgt_act_d   = tgt_act_q;
    rem_d       = rem_q;
    last_d      = last_q;
    cmd_d       = cmd_q;
    elapsed_d   = elapsed_q;
    adv_d       = adv_q;
    step_d      = step_q;
    npos_d      = npos_q;
    bound_d     = bound_q;
    fin_d       = fin_q;
    s_d         = s_q;
    cmp_d       = cmp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (ctrl_i.act)
      ACT_LATCH: begin
        if (in_valid_i) begin
          cmd_d = in_item_i;
        end
      end
      // Set: stops the sweep; zero releases PWM, a position at or beyond an endpoint is stored with PWM released.
      ACT_SET_CMD: begin
        dir_d = DIR_STOP;
        rem_d = '0;
        if (cmd_q.position_value == 16'd0) begin
          pwm_d = 1'b0;
        end else begin
          pos_d = set_pos;
          pwm_d = !(set_pos <= cfg_i.open_limit || set_pos >= cfg_i.closed_limit);
        end
      end
      // Sweep direction: stop, or start unless already at that limit.
      ACT_DIR_CMD: begin
        tgt_act_d = 1'b0;
        rem_d     = '0;
        if (cmd_q.direction == DIR_STOP || cmd_q.direction == DIR_UNUSED) begin
          dir_d = DIR_STOP;
          pwm_d = 1'b0;
        end else begin
          last_d = cmd_q.now_ms;
          if (cmd_q.direction == DIR_OPEN && pos_q <= cfg_i.open_limit) begin
            pos_d = cfg_i.open_limit;
            dir_d = DIR_STOP;
            pwm_d = 1'b0;
          end else if (cmd_q.direction == DIR_CLOSE && pos_q >= cfg_i.closed_limit) begin
            pos_d = cfg_i.closed_limit;
            dir_d = DIR_STOP;
            pwm_d = 1'b0;
          end else begin
            if (!pwm_q) begin
              pos_d = cur_clamped;
              pwm_d = 1'b1;
            end
            dir_d = cmd_q.direction;
          end
        end
      end
      // Sweep to target: nothing happens when the target equals the position.
      ACT_TGT_CMD: begin
        if (tgt_lim != pos_q) begin
          rem_d     = '0;
          last_d    = cmd_q.now_ms;
          tgt_d     = tgt_lim;
          tgt_act_d = 1'b1;
          if (!pwm_q) begin
            pos_d = cur_clamped;
            pwm_d = 1'b1;
          end
          dir_d = (tgt_lim > tgt_base) ? DIR_CLOSE : DIR_OPEN;
        end
      end
      ACT_ELAPSED: begin
        elapsed_d = cmd_q.now_ms - last_q;
      end
      ACT_ADD_REM: begin
        adv_d = {1'b0, prod_q[47:0]} + {39'b0, rem_q};
      end
      // A very large advance always reaches the bound.
      ACT_SAT_IF_BIG: begin
        if (adv_big) begin
          step_d = '1;
        end
      end
      ACT_QUOT: begin
        step_d = prod_q[RECIP_SHIFT +: STEP_W];
      end
      // The reciprocal quotient may be one short; fix it up here.
      ACT_REM_FIX: begin
        if (rfix >= {1'b0, MS_PER_S}) begin
          rem_d  = 10'(rfix - {1'b0, MS_PER_S});
          step_d = step_q + STEP_W'(1);
        end else begin
          rem_d = rfix[9:0];
        end
      end
      ACT_EVAL: begin
        last_d  = cmd_q.now_ms;
        bound_d = eval_bound;
        fin_d   = eval_fin;
        npos_d  = eval_npos;
      end
      ACT_DRIVE_NPOS: begin
        pos_d = clamp_pos(npos_q, cfg_i.open_limit, cfg_i.closed_limit);
        pwm_d = 1'b1;
      end
      // End of a sweep: a target sweep holds with PWM on, a free one releases.
      ACT_FINISH: begin
        dir_d = DIR_STOP;
        rem_d = '0;
        if (tgt_act_q) begin
          tgt_act_d = 1'b0;
          pos_d     = clamp_pos(bound_q, cfg_i.open_limit, cfg_i.closed_limit);
          pwm_d     = 1'b1;
        end else begin
          pos_d = bound_q;
          pwm_d = 1'b0;
        end
      end
      ACT_SAT_S: begin
        s_d = (pos_q > cfg_i.pwm_scale) ? cfg_i.pwm_scale : pos_q;
      end
      ACT_CMP_FROM_DIV: begin
        cmp_d = div_quot;
      end
      ACT_CMP_ZERO: begin
        cmp_d = '0;
      end
      ACT_LOAD_OUT: begin
        if (!out_busy) begin
          out_d.position      = pos_q;
          out_d.pwm_enable    = pwm_q;
          out_d.compare_value = cmp_q;
          out_d.sweep_state   = dir_q;
          out_valid_d         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Compare scaling divider.
  spr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.act == ACT_DIV_START),
    .dividend_i (prod_q[31:0]),
    .divisor_i  (cfg_i.pwm_scale),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= RST_POSITION;
      pwm_q       <= 1'b0;
      dir_q       <= DIR_STOP;
      tgt_q       <= '0;
      tgt_act_q   <= 1'b0;
      rem_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      pwm_q       <= pwm_d;
      dir_q       <= dir_d;
      tgt_q       <= tgt_d;
      tgt_act_q   <= tgt_act_d;
      rem_q       <= rem_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    elapsed_q <= elapsed_d;
    prod_q    <= prod_d;
    adv_q     <= adv_d;
    step_q    <= step_d;
    npos_q    <= npos_d;
    bound_q   <= bound_d;
    fin_q     <= fin_d;
    s_q       <= s_d;
    cmp_q     <= cmp_d;
    out_q     <= out_d;
  end

  // Status back to the sequencer.
  always_comb begin
    stat_o.op        = cmd_q.operation;
    stat_o.no_in     = !in_valid_i;
    stat_o.out_busy  = out_busy;
    stat_o.dir_zero  = dir_q == DIR_STOP;
    stat_o.el_short  = elapsed_q < {16'b0, cfg_i.tick_min_ms};
    stat_o.adv_big   = adv_big;
    stat_o.step_zero = step_q == '0;
    stat_o.fin       = fin_q;
    stat_o.cmp_off   = !pwm_q || pos_q == 16'd0 || cfg_i.pwm_scale == 16'd0;
    stat_o.div_busy  = div_busy;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SPR_ASSERT(a_rem_range, rem_q < MS_PER_S, "rate remainder reached a full second")
  `SPR_ASSERT_ALWAYS(a_dir_code, dir_q != DIR_UNUSED, "sweep state holds the unused code")
  `SPR_ASSERT(a_cmp_off, out_valid_q |-> (out_q.pwm_enable || out_q.compare_value == 16'd0), "compare value set with PWM off")

endmodule

// ===== hw/rtl/servo_position_sweep_ramp_top.sv =====
// ----------------------------------------------------------------------------
// Servo position sweep ramp
// Command-driven servo position generator with sweep and PWM compare output.
// ----------------------------------------------------------------------------
// Each input item is a command (set, sweep direction, sweep to target or time
// tick) and yields exactly one result item holding position, PWM enable,
// compare value and sweep state. Items are handled one at a time by a
// microcoded sequencer over a shared multiplier and a bit-serial divider. The
// sequencer holds in its output step for as long as an earlier result still
// waits in the output register. The compare division dominates whenever PWM
// is on with nonzero position and scale, a tick adds the rate arithmetic.
// A new item is taken while the previous result still waits in the output
// register. Configuration writes belong to idle periods only. There is no
// clearing pass after reset.
module servo_position_sweep_ramp_top
  import spr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  cfg_t  cfg_q, cfg_d;
  ctrl_t ctrl;
  stat_t stat;

  // Register file write decode; indices beyond the map are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OPEN_LIMIT:   cfg_d.open_limit   = cfg_wdata_i;
        CFG_CLOSED_LIMIT: cfg_d.closed_limit = cfg_wdata_i;
        CFG_PWM_SCALE:    cfg_d.pwm_scale    = cfg_wdata_i;
        CFG_PWM_TOP:      cfg_d.pwm_top      = cfg_wdata_i;
        CFG_SWEEP_RATE:   cfg_d.sweep_rate   = cfg_wdata_i;
        CFG_TICK_MIN_MS:  cfg_d.tick_min_ms  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_limit   <= RST_OPEN_LIMIT;
      cfg_q.closed_limit <= RST_CLOSED_LIMIT;
      cfg_q.pwm_scale    <= RST_PWM_SCALE;
      cfg_q.pwm_top      <= RST_PWM_TOP;
      cfg_q.sweep_rate   <= RST_SWEEP_RATE;
      cfg_q.tick_min_ms  <= RST_TICK_MIN_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Items are taken only in the fetch step of the program.
  assign in_ready_o = ctrl.act == ACT_LATCH;

  spr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  spr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sim/servo_ramp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo ramp result checker
// Watches the register port and both item channels of the servo sweep ramp.
// Predicts the result of every accepted command and compares it, field by
// field, with the result items that the block hands out.
// ----------------------------------------------------------------------------
module servo_ramp_checker
  import spr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_item_i,
  output int                   errors_o,
  output int                   pending_o
);

  // Shadow copy of the registers and of the servo state.
  cfg_t        regs;
  logic [15:0] pos_q;
  logic        pwm_on;
  logic [1:0]  sweep_dir;
  logic [15:0] goal_pos;
  logic        goal_on;
  logic [9:0]  carry_ms;
  logic [31:0] last_ms;

  out_item_t   expected_results[$];
  int          error_count = 0;

  // Nonzero positions are pulled inside the limits, the open limit first.
  function automatic logic [15:0] pull_inside(input logic [15:0] s);
    if (s == 16'd0) return 16'd0;
    if (s < regs.open_limit) return regs.open_limit;
    if (s > regs.closed_limit) return regs.closed_limit;
    return s;
  endfunction

  // Compare value: position scaled to the counter top, saturating at the scale.
  function automatic logic [15:0] compare_for();
    logic [63:0] s;
    if (!pwm_on || pos_q == 16'd0 || regs.pwm_scale == 16'd0) return 16'd0;
    s = (pos_q > regs.pwm_scale) ? 64'(regs.pwm_scale) : 64'(pos_q);
    return 16'(s * 64'(regs.pwm_top) / 64'(regs.pwm_scale));
  endfunction

  task automatic engage(input logic [15:0] s);
    pos_q  = pull_inside(s);
    pwm_on = 1'b1;
  endtask

  // A sweep that reaches its bound stops there; a target ramp keeps PWM on.
  task automatic end_sweep(input logic [15:0] bound);
    pos_q     = bound;
    sweep_dir = DIR_STOP;
    carry_ms  = '0;
    if (goal_on) begin
      goal_on = 1'b0;
      engage(bound);
    end else begin
      pwm_on = 1'b0;
    end
  endtask

  // Time tick: advance by rate times elapsed milliseconds over 1000, carrying the rest.
  task automatic run_tick(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [63:0] advance;
    logic [63:0] stride;
    logic [63:0] here;
    logic [15:0] bound;
    if (sweep_dir == DIR_STOP) return;
    elapsed = now - last_ms;
    if (elapsed < 32'(regs.tick_min_ms)) return;
    advance  = 64'(regs.sweep_rate) * 64'(elapsed) + 64'(carry_ms);
    stride   = advance / 64'd1000;
    carry_ms = 10'(advance % 64'd1000);
    if (stride == 64'd0) return;
    last_ms = now;
    here    = 64'(pos_q);
    if (sweep_dir == DIR_OPEN) begin
      bound = goal_on ? goal_pos : regs.open_limit;
      if (here <= 64'(bound) + stride) begin
        end_sweep(bound);
        return;
      end
      here = here - stride;
    end else begin
      bound = goal_on ? goal_pos : regs.closed_limit;
      if (here + stride >= 64'(bound)) begin
        end_sweep(bound);
        return;
      end
      here = here + stride;
    end
    engage(here[15:0]);
  endtask

  // Apply one command to the shadow state and work out its result item.
  task automatic servo_after(input in_item_t cmd, output out_item_t res);
    logic [15:0] aim;
    case (cmd.operation)
      OP_SET: begin
        sweep_dir = DIR_STOP;
        carry_ms  = '0;
        if (cmd.position_value == 16'd0) begin
          pwm_on = 1'b0;
        end else begin
          pos_q = pull_inside(cmd.position_value);
          if (pos_q <= regs.open_limit || pos_q >= regs.closed_limit) pwm_on = 1'b0;
          else engage(pos_q);
        end
      end
      OP_DIR: begin
        goal_on = 1'b0;
        if (cmd.direction == DIR_STOP || cmd.direction == DIR_UNUSED) begin
          sweep_dir = DIR_STOP;
          carry_ms  = '0;
          pwm_on    = 1'b0;
        end else begin
          carry_ms = '0;
          last_ms  = cmd.now_ms;
          if (cmd.direction == DIR_OPEN && pos_q <= regs.open_limit) begin
            pos_q     = regs.open_limit;
            sweep_dir = DIR_STOP;
            pwm_on    = 1'b0;
          end else if (cmd.direction == DIR_CLOSE && pos_q >= regs.closed_limit) begin
            pos_q     = regs.closed_limit;
            sweep_dir = DIR_STOP;
            pwm_on    = 1'b0;
          end else begin
            if (!pwm_on) engage(pos_q);
            sweep_dir = cmd.direction;
          end
        end
      end
      OP_TGT: begin
        aim = cmd.position_value;
        if (aim < regs.open_limit) aim = regs.open_limit;
        else if (aim > regs.closed_limit) aim = regs.closed_limit;
        // A target equal to the present position leaves everything alone.
        if (aim != pos_q) begin
          carry_ms = '0;
          last_ms  = cmd.now_ms;
          goal_pos = aim;
          goal_on  = 1'b1;
          if (!pwm_on) engage(pos_q);
          sweep_dir = (aim > pos_q) ? DIR_CLOSE : DIR_OPEN;
        end
      end
      default: begin
        run_tick(cmd.now_ms);
      end
    endcase
    res.position      = pos_q;
    res.pwm_enable    = pwm_on;
    res.compare_value = compare_for();
    res.sweep_state   = sweep_dir;
  endtask

  // Compare a result item with the oldest prediction.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result item with no command waiting: %p", got);
      error_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      error_count++;
    end
    if (got.pwm_enable !== want.pwm_enable) begin
      $error("pwm_enable: expected %0d, got %0d", want.pwm_enable, got.pwm_enable);
      error_count++;
    end
    if (got.compare_value !== want.compare_value) begin
      $error("compare_value: expected %0d, got %0d", want.compare_value,
             got.compare_value);
      error_count++;
    end
    if (got.sweep_state !== want.sweep_state) begin
      $error("sweep_state: expected %0d, got %0d", want.sweep_state, got.sweep_state);
      error_count++;
    end
  endtask

  // Register writes first, then results leaving, then commands arriving.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t predicted;
    if (!rst_ni) begin
      regs.open_limit   = RST_OPEN_LIMIT;
      regs.closed_limit = RST_CLOSED_LIMIT;
      regs.pwm_scale    = RST_PWM_SCALE;
      regs.pwm_top      = RST_PWM_TOP;
      regs.sweep_rate   = RST_SWEEP_RATE;
      regs.tick_min_ms  = RST_TICK_MIN_MS;
      pos_q     = RST_POSITION;
      pwm_on    = 1'b0;
      sweep_dir = DIR_STOP;
      goal_pos  = '0;
      goal_on   = 1'b0;
      carry_ms  = '0;
      last_ms   = '0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OPEN_LIMIT:   regs.open_limit   = cfg_wdata_i;
          CFG_CLOSED_LIMIT: regs.closed_limit = cfg_wdata_i;
          CFG_PWM_SCALE:    regs.pwm_scale    = cfg_wdata_i;
          CFG_PWM_TOP:      regs.pwm_top      = cfg_wdata_i;
          CFG_SWEEP_RATE:   regs.sweep_rate   = cfg_wdata_i;
          CFG_TICK_MIN_MS:  regs.tick_min_ms  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) begin
        servo_after(in_item_i, predicted);
        expected_results.push_back(predicted);
      end
    end
    pending_o <= expected_results.size();
    errors_o  <= error_count;
  end

endmodule

// ===== sim/tb_servo_position_sweep_ramp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo position sweep ramp testbench
// Drives commands into the servo ramp block under a series of register
// settings: a directed run over the corner cases, then sweeps and target
// ramps with random timing mixed with random commands. A checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_servo_position_sweep_ramp_top;
  import spr_pkg::*;

  localparam int SETTING_PHASES  = 9;
  localparam int ITEMS_PER_PHASE = 92;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_item_o;

  int          mismatches;
  int          outstanding;
  bit          steady;
  cfg_t        live;
  logic [31:0] ms_now;
  int          sent_items;

  servo_position_sweep_ramp_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  servo_ramp_checker i_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .errors_o    (mismatches),
    .pending_o   (outstanding)
  );

  // 50 MHz clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The receiver stalls at random, with a chance of 18 in a hundred, except in steady runs.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 18);
  end

  // Hand one command to the block, with random gaps before it outside steady runs.
  task automatic issue(input logic [1:0] op, input logic [15:0] val,
                       input logic [1:0] dir, input logic [31:0] now);
    in_item_t cmd;
    cmd.operation      = op;
    cmd.position_value = val;
    cmd.direction      = dir;
    cmd.now_ms         = now;
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= cmd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_items++;
  endtask

  // Hold off until every result has come back, then linger a while.
  task automatic drain(input int linger);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (linger) @(negedge clk_i);
  endtask

  task automatic poke(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    poke(CFG_OPEN_LIMIT, s.open_limit);
    poke(CFG_CLOSED_LIMIT, s.closed_limit);
    poke(CFG_PWM_SCALE, s.pwm_scale);
    poke(CFG_PWM_TOP, s.pwm_top);
    poke(CFG_SWEEP_RATE, s.sweep_rate);
    poke(CFG_TICK_MIN_MS, s.tick_min_ms);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    live = s;
  endtask

  // Register settings per phase: extremes and crossed limits first, then the reset settings, then random.
  function automatic cfg_t settings_for(input int phase);
    cfg_t s;
    s.open_limit   = RST_OPEN_LIMIT;
    s.closed_limit = RST_CLOSED_LIMIT;
    s.pwm_scale    = RST_PWM_SCALE;
    s.pwm_top      = RST_PWM_TOP;
    s.sweep_rate   = RST_SWEEP_RATE;
    s.tick_min_ms  = RST_TICK_MIN_MS;
    case (phase)
      0: begin
        s = '{open_limit: 16'd1, closed_limit: 16'hFFFF, pwm_scale: 16'hFFFF,
              pwm_top: 16'hFFFF, sweep_rate: 16'hFFFF, tick_min_ms: 16'd0};
      end
      1: begin
        s = '{open_limit: 16'd1, closed_limit: 16'd2, pwm_scale: 16'd1,
              pwm_top: 16'd1, sweep_rate: 16'd0, tick_min_ms: 16'hFFFF};
      end
      2: begin
        s = '{open_limit: 16'd3000, closed_limit: 16'd1000, pwm_scale: 16'd2500,
              pwm_top: 16'd50000, sweep_rate: 16'd1500, tick_min_ms: 16'd5};
      end
      3: begin
        s = '{open_limit: 16'd100, closed_limit: 16'd60000, pwm_scale: 16'd1000,
              pwm_top: 16'hFFFF, sweep_rate: 16'd20000, tick_min_ms: 16'd1};
      end
      4: ;
      default: begin
        s.open_limit = 16'($urandom_range(1, 30000));
        if ($urandom_range(0, 9) == 0)
          s.closed_limit = 16'($urandom_range(1, s.open_limit));
        else
          s.closed_limit = 16'($urandom_range(s.open_limit, 65535));
        s.pwm_scale = 16'($urandom_range(1, 65535));
        s.pwm_top   = 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 9) < 7) s.sweep_rate = 16'($urandom_range(0, 5000));
        else s.sweep_rate = 16'($urandom_range(0, 65535));
        s.tick_min_ms = 16'($urandom_range(0, 100));
      end
    endcase
    return s;
  endfunction

  // Milliseconds between ticks: mostly past the minimum, some short, a few huge.
  function automatic logic [31:0] tick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'($urandom_range(0, live.tick_min_ms));
    if (r < 20) return 32'($urandom());
    return 32'(live.tick_min_ms) + 32'($urandom_range(0, 400));
  endfunction

  // Target positions mostly between the limits, now and then anywhere.
  function automatic logic [15:0] aim_value();
    logic [15:0] lo;
    logic [15:0] hi;
    int unsigned r;
    lo = (live.open_limit < live.closed_limit) ? live.open_limit : live.closed_limit;
    hi = (live.open_limit < live.closed_limit) ? live.closed_limit : live.open_limit;
    r  = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(lo, hi));
    if (r == 7) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic noise_item();
    logic [31:0] now;
    int unsigned r;
    r   = $urandom_range(0, 9);
    now = ($urandom_range(0, 1) == 1) ? ms_now : 32'($urandom());
    if (r == 0) issue(2'($urandom_range(0, 3)), 16'd0, 2'($urandom_range(0, 3)), now);
    else if (r == 1) issue(2'($urandom_range(0, 3)), 16'hFFFF, 2'($urandom_range(0, 3)), now);
    else issue(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
               2'($urandom_range(0, 3)), now);
  endtask

  // A sweep or target ramp followed by a run of ticks at advancing time.
  task automatic sweep_burst();
    int ticks;
    ticks = $urandom_range(2, 10);
    if ($urandom_range(0, 1) == 1)
      issue(OP_DIR, 16'($urandom_range(0, 65535)), 2'($urandom_range(1, 2)), ms_now);
    else
      issue(OP_TGT, aim_value(), 2'($urandom_range(0, 3)), ms_now);
    repeat (ticks) begin
      if ($urandom_range(0, 9) == 0) noise_item();
      ms_now = ms_now + tick_gap();
      issue(OP_TICK, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)), ms_now);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_OPEN_LIMIT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    steady      = 1'b0;
    live        = settings_for(4);
    ms_now      = '0;
    sent_items  = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed run under the reset settings.
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd0);          // tick with no sweep running
    issue(OP_SET, 16'd0, DIR_STOP, 32'd0);           // release
    issue(OP_SET, 16'd1500, DIR_STOP, 32'd0);
    issue(OP_SET, 16'd500, DIR_STOP, 32'd0);         // clamps to the open endpoint
    issue(OP_SET, 16'hFFFF, DIR_STOP, 32'd0);        // clamps to the closed endpoint
    issue(OP_SET, 16'd1999, DIR_STOP, 32'd0);
    issue(OP_DIR, 16'd0, DIR_UNUSED, 32'd0);         // unused direction stops
    issue(OP_DIR, 16'd0, DIR_CLOSE, 32'd1000);
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd1010);       // too soon
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd1030);       // runs into the closed limit
    issue(OP_DIR, 16'd0, DIR_CLOSE, 32'd1040);       // already at the limit
    issue(OP_DIR, 16'd0, DIR_OPEN, 32'd2000);
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd2023);       // leaves a remainder
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd2025);
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd2045);       // remainder carried in
    issue(OP_DIR, 16'd0, DIR_STOP, 32'd2050);
    issue(OP_SET, 16'd1234, DIR_STOP, 32'd2060);
    issue(OP_TGT, 16'd1234, DIR_STOP, 32'd3000);     // target is the present position
    issue(OP_TGT, 16'd0, DIR_STOP, 32'd3000);        // zero target pulled to open limit
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd2999);       // wrapped time reaches the target
    issue(OP_TGT, 16'hFFFF, DIR_STOP, 32'd5000);
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd5100);
    issue(OP_TICK, 16'd0, DIR_STOP, 32'd5100);
    issue(OP_TICK, 16'hFFFF, DIR_UNUSED, 32'hFFFF_FFFF);
    ms_now = 32'd10000;

    // Random runs, one per register setting.
    for (int phase = 0; phase < SETTING_PHASES; phase++) begin
      int quota;
      quota = sent_items + ITEMS_PER_PHASE;
      drain(40);
      load_settings(settings_for(phase));
      steady = (phase == 4);
      while (sent_items < quota) begin
        if ($urandom_range(0, 99) < 3) drain(0);
        if ($urandom_range(0, 99) < 65) sweep_burst();
        else noise_item();
      end
    end

    drain(60);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
